>>> rtl/tcoc_pkg.sv
// Package for the tensor chain order cost block: widths, sequencer states
// and saturating arithmetic helpers. No dependencies.
package tcoc_pkg;

  localparam int COST_W  = 64;
  localparam int FIELD_W = 10;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_MASK,
    ST_PROD,
    ST_ROWS,
    ST_COLJ,
    ST_KRD,
    ST_KACC,
    ST_KCMP,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              ovf;
    logic [COST_W-1:0] val;
  } sat_t;

  function automatic sat_t sat_mul(input logic [COST_W-1:0] a, input logic [FIELD_W-1:0] b);
    logic [COST_W+FIELD_W-1:0] p;
    sat_t r;
    p = a * b;
    r.ovf = |p[COST_W+FIELD_W-1:COST_W];
    r.val = r.ovf ? {COST_W{1'b1}} : p[COST_W-1:0];
    return r;
  endfunction

  function automatic sat_t sat_add(input logic [COST_W-1:0] a, input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    sat_t r;
    s = {1'b0, a} + {1'b0, b};
    r.ovf = s[COST_W];
    r.val = r.ovf ? {COST_W{1'b1}} : s[COST_W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/tensor_chain_order_cost.sv
// Top level of the tensor chain order cost block: tensor store, interval
// memory and the interval search sequencer. Depends on tcoc_pkg.
//
// Input stream s_*: one tensor per item, accepted while the block is loading,
// one item per cycle. s_tlast marks the last tensor and starts the search.
// Output stream m_*: one item per chain, the minimum cost in m_tdata and the
// saturation and overflow flags in m_tuser.
// After the last item the search runs over every interval: per interval a
// setup that walks the batch dimensions, rows and columns, then a step per
// split point, paced by the one saturating 64x10 multiplier and the two-port
// interval memory. A one-tensor chain skips the search. s_tready is low
// during the search.
// The result waits in an output register; the next chain loads while it
// waits, and a finished search holds until the receiver takes the old result.
// Reset (rst, synchronous) empties the chain and drops a pending result; the
// memories need no clearing.
module tensor_chain_order_cost import tcoc_pkg::*; #(
  parameter int MAX_TENSORS = 64,
  parameter int BATCH_DIMS  = 4,
  localparam int IN_W = ((BATCH_DIMS + 2) * FIELD_W + 7) / 8 * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // batch_dim_0.., row_count, col_count
  input  logic             s_tlast,   // last_tensor
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [COST_W-1:0] m_tdata,  // min_cost
  output logic [1:0]       m_tuser    // chain_too_long, cost_saturated
);

  localparam int IW = $clog2(MAX_TENSORS);
  localparam int CW = $clog2(MAX_TENSORS + 1);
  localparam int DW = (BATCH_DIMS > 1) ? $clog2(BATCH_DIMS) : 1;
  localparam int EW = BATCH_DIMS + COST_W;
  localparam int TW = 2 * FIELD_W;

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic                 ovf_chain;
  logic [CW-1:0]        n;
  logic [IW-1:0]        len, i, k, j, kr;
  logic [DW-1:0]        d;
  logic [BATCH_DIMS-1:0] mask, in_mask;
  logic [FIELD_W-1:0]   rows_i;
  logic [COST_W-1:0]    prod, best, t1, mterm;
  logic                 sat_flag;
  logic [FIELD_W-1:0]   bs [BATCH_DIMS];

  logic [EW-1:0]        imem [2**(2*IW)];
  logic                 iwr_en, ird_en;
  logic [2*IW-1:0]      iwr_addr, ira_addr, irb_addr;
  logic [EW-1:0]        iwr_data, ira_q, irb_q;

  logic [TW-1:0]        tmem [2**IW];
  logic                 ta_en, tb_en;
  logic [IW-1:0]        ta_addr, tb_addr;
  logic [TW-1:0]        ta_q, tb_q;

  logic                 accept, store, out_free;
  logic [CW-1:0]        n_new;
  logic                 more_i, more_len;
  logic [FIELD_W-1:0]   in_rows, in_cols;
  sat_t                 sm, sa;

  assign accept   = s_tvalid & s_tready;
  assign store    = accept && (count != CW'(MAX_TENSORS));
  assign n_new    = store ? count + CW'(1) : count;
  assign in_rows  = s_tdata[BATCH_DIMS*FIELD_W +: FIELD_W];
  assign in_cols  = s_tdata[(BATCH_DIMS+1)*FIELD_W +: FIELD_W];
  assign j        = i + len;
  assign more_i   = ((CW+1)'(i) + (CW+1)'(len) + (CW+1)'(1)) < (CW+1)'(n);
  assign more_len = ((CW+1)'(len) + (CW+1)'(1)) < (CW+1)'(n);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    for (int b = 0; b < BATCH_DIMS; b++) begin
      in_mask[b] = s_tdata[b*FIELD_W +: FIELD_W] != FIELD_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && s_tlast) begin
          state_next = (n_new == CW'(1)) ? ST_DONE : ST_START;
        end
      end
      ST_START: state_next = ST_MASK;
      ST_MASK:  state_next = ST_PROD;
      ST_PROD:  state_next = (d == DW'(BATCH_DIMS - 1)) ? ST_ROWS : ST_PROD;
      ST_ROWS:  state_next = ST_COLJ;
      ST_COLJ:  state_next = ST_KRD;
      ST_KRD:   state_next = ST_KACC;
      ST_KACC:  state_next = ST_KCMP;
      ST_KCMP:  state_next = (k + IW'(1) == j) ? ST_WRITE : ST_KACC;
      ST_WRITE: begin
        if (more_i || more_len) begin
          state_next = ST_START;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:  state_next = out_free ? ST_LOAD : ST_DONE;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_LOAD);
    case (state)
      ST_START: kr = i;
      ST_KCMP:  kr = k + IW'(1);
      default:  kr = k;
    endcase
    iwr_en   = store || (state == ST_WRITE);
    iwr_addr = (state == ST_WRITE) ? {i, j} : {count[IW-1:0], count[IW-1:0]};
    iwr_data = (state == ST_WRITE) ? {mask, best} : {in_mask, {COST_W{1'b0}}};
    ird_en   = (state == ST_START) || (state == ST_KRD) || (state == ST_KCMP);
    ira_addr = {i, kr};
    irb_addr = {kr + IW'(1), j};
    ta_en    = (state == ST_START) || (state == ST_MASK);
    ta_addr  = (state == ST_START) ? i : j;
    tb_en    = ird_en;
    tb_addr  = kr;
  end

  always_ff @(posedge clk) begin
    if (iwr_en) begin
      imem[iwr_addr] <= iwr_data;
    end
    if (ird_en) begin
      ira_q <= imem[ira_addr];
      irb_q <= imem[irb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      tmem[count[IW-1:0]] <= {in_rows, in_cols};
    end
    if (ta_en) begin
      ta_q <= tmem[ta_addr];
    end
    if (tb_en) begin
      tb_q <= tmem[tb_addr];
    end
  end

  always_comb begin
    case (state)
      ST_PROD: sm = sat_mul(prod, bs[d]);
      ST_ROWS: sm = sat_mul(prod, rows_i);
      ST_COLJ: sm = sat_mul(prod, ta_q[FIELD_W-1:0]);
      default: sm = sat_mul(prod, tb_q[FIELD_W-1:0]);
    endcase
    if (state == ST_KCMP) begin
      sa = sat_add(t1, mterm);
    end else begin
      sa = sat_add(ira_q[COST_W-1:0], irb_q[COST_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf_chain <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (store) begin
            count <= count + CW'(1);
          end else if (accept) begin
            ovf_chain <= 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count     <= '0;
            ovf_chain <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        if (store) begin
          for (int b = 0; b < BATCH_DIMS; b++) begin
            if (in_mask[b]) begin
              bs[b] <= s_tdata[b*FIELD_W +: FIELD_W];
            end
          end
        end
        if (accept && s_tlast) begin
          n        <= n_new;
          len      <= IW'(1);
          i        <= '0;
          sat_flag <= 1'b0;
          best     <= '0;
        end
      end
      ST_MASK: begin
        mask   <= ira_q[EW-1 -: BATCH_DIMS] | irb_q[EW-1 -: BATCH_DIMS];
        rows_i <= ta_q[TW-1 -: FIELD_W];
        prod   <= COST_W'(1);
        d      <= '0;
      end
      ST_PROD: begin
        if (mask[d]) begin
          prod <= sm.val;
          if (sm.ovf) sat_flag <= 1'b1;
        end
        d <= d + DW'(1);
      end
      ST_ROWS: begin
        prod <= sm.val;
        if (sm.ovf) sat_flag <= 1'b1;
      end
      ST_COLJ: begin
        prod <= sm.val;
        if (sm.ovf) sat_flag <= 1'b1;
        k    <= i;
        best <= {COST_W{1'b1}};
      end
      ST_KACC: begin
        t1    <= sa.val;
        mterm <= sm.val;
        if (sa.ovf || sm.ovf) sat_flag <= 1'b1;
      end
      ST_KCMP: begin
        if (sa.val < best) best <= sa.val;
        if (sa.ovf) sat_flag <= 1'b1;
        k <= k + IW'(1);
      end
      ST_WRITE: begin
        if (more_i) begin
          i <= i + IW'(1);
        end else begin
          i   <= '0;
          len <= len + IW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= best;
          m_tuser <= {ovf_chain, sat_flag};
        end
      end
      default: ;
    endcase
  end

endmodule
